@@ hw/rtl/bmsr_pkg.sv @@
// bmsr_pkg: shared types and constants of the status frame receiver
package bmsr_pkg;

    // event kinds on the input stream
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_POLL = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LEN   = 3'd1;
    localparam logic [2:0] ST_BAD_SUM   = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
    localparam logic [2:0] ST_BAD_CMD   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT   = 3'd5;

    // follow-up request codes
    localparam logic [1:0] FOLLOW_NONE  = 2'd0;
    localparam logic [1:0] FOLLOW_CELLS = 2'd1;
    localparam logic [1:0] FOLLOW_NEXT  = 2'd2;

    // frame layout
    localparam logic [7:0] START_BYTE   = 8'hA5;
    localparam logic [7:0] FRAME_LEN    = 8'h08;
    localparam logic [3:0] IDX_START    = 4'd0;
    localparam logic [3:0] IDX_ADDR     = 4'd1;
    localparam logic [3:0] IDX_CMD      = 4'd2;
    localparam logic [3:0] IDX_LEN      = 4'd3;
    localparam logic [3:0] IDX_CHECKSUM = 4'd12;

    // command bytes
    localparam logic [7:0] CMD_MAIN  = 8'h90;
    localparam logic [7:0] CMD_CELLS = 8'h91;
    localparam logic [7:0] CMD_TEMPS = 8'h92;
    localparam logic [7:0] CMD_VOLTS = 8'h95;
    localparam logic [7:0] CMD_LAST  = 8'h98;

    // unit offsets
    localparam logic [16:0] CURRENT_OFFSET = 17'd30000;
    localparam logic [16:0] TEMP_OFFSET    = 17'd40;
    localparam logic [16:0] INDEX_OFFSET   = 17'd1;

    // configuration register indexes and reset values
    localparam logic [1:0]  CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0]  CFG_CELLS_IN_PACK  = 2'd1;
    localparam logic [1:0]  CFG_REPLY_TIMEOUT  = 2'd2;
    localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'd1;
    localparam logic [5:0]  RST_CELLS_IN_PACK  = 6'd16;
    localparam logic [15:0] RST_REPLY_TIMEOUT  = 16'd500;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [5:0]  cells_in_pack;
        logic [15:0] reply_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [16:0] value_a;
        logic signed [16:0] value_b;
        logic signed [16:0] value_c;
        logic signed [16:0] value_d;
        logic signed [10:0] cell_base;
        logic [1:0]         cell_count;
        logic               more_frames;
        logic [1:0]         followup;
        logic               keep_awaiting;
    } decode_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         command;
        logic [63:0]        payload;
        logic signed [16:0] value_a;
        logic signed [16:0] value_b;
        logic signed [16:0] value_c;
        logic signed [16:0] value_d;
        logic signed [10:0] cell_base;
        logic [1:0]         cell_count;
        logic               more_frames;
        logic [1:0]         followup;
    } result_t;

endpackage

@@ hw/rtl/bmsr_decode.sv @@
// bmsr_decode: converts a complete frame into integer unit values
module bmsr_decode (
    input  logic [7:0]       frame_command,
    input  logic [63:0]      frame_data,
    input  logic [5:0]       cells_in_pack,
    output bmsr_pkg::decode_t dec
);
    import bmsr_pkg::*;

    logic [7:0]         db [8];
    logic [9:0]         frame_x3;
    logic signed [10:0] base;
    logic signed [10:0] cells_s;
    logic signed [10:0] remaining;
    logic               base_in_pack;
    logic [1:0]         count;
    logic               more;

    // data 0 sits in the top byte
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            db[k] = frame_data[63 - 8 * k -: 8];
        end
    end

    // cell frame bookkeeping, base = (frame - 1) * 3
    assign frame_x3     = {1'b0, db[0], 1'b0} + {2'b00, db[0]};
    assign base         = $signed({1'b0, frame_x3} - 11'd3);
    assign cells_s      = $signed({5'b00000, cells_in_pack});
    assign base_in_pack = base < cells_s;
    assign remaining    = cells_s - base;
    assign count        = !base_in_pack ? 2'd0 :
                          (remaining > 11'sd3) ? 2'd3 : remaining[1:0];
    // frame < (cells + 2) / 3 is the same as 3 * frame < cells
    assign more         = frame_x3 < {4'b0000, cells_in_pack};

    // per-command field mapping
    always_comb
    begin
        dec = '0;
        case (frame_command)
            CMD_MAIN:
            begin
                dec.value_a       = {1'b0, db[0], db[1]};
                dec.value_b       = {1'b0, db[4], db[5]} - CURRENT_OFFSET;
                dec.value_c       = {1'b0, db[6], db[7]};
                dec.followup      = FOLLOW_CELLS;
                dec.keep_awaiting = 1'b1;
            end
            CMD_CELLS:
            begin
                dec.value_a       = {1'b0, db[0], db[1]};
                dec.value_b       = {9'd0, db[2]} - INDEX_OFFSET;
                dec.value_c       = {1'b0, db[3], db[4]};
                dec.value_d       = {9'd0, db[5]} - INDEX_OFFSET;
                dec.followup      = FOLLOW_NEXT;
                dec.keep_awaiting = 1'b1;
            end
            CMD_TEMPS:
            begin
                dec.value_a = {9'd0, db[0]} - TEMP_OFFSET;
                dec.value_b = {9'd0, db[1]} - INDEX_OFFSET;
                dec.value_c = {9'd0, db[2]} - TEMP_OFFSET;
                dec.value_d = {9'd0, db[3]} - INDEX_OFFSET;
            end
            CMD_VOLTS:
            begin
                dec.value_a       = (count >= 2'd1) ? {1'b0, db[1], db[2]} : 17'd0;
                dec.value_b       = (count >= 2'd2) ? {1'b0, db[3], db[4]} : 17'd0;
                dec.value_c       = (count == 2'd3) ? {1'b0, db[5], db[6]} : 17'd0;
                dec.cell_base     = base;
                dec.cell_count    = count;
                dec.more_frames   = more;
                dec.keep_awaiting = more;
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/bmsr_frame.sv @@
// bmsr_frame: reply tracking, frame collection, checks and result forming
module bmsr_frame (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [1:0]         func,
    input  logic [7:0]         rx_byte,
    input  bmsr_pkg::cfg_t     cfg,
    output logic               res_valid,
    output bmsr_pkg::result_t  res
);
    import bmsr_pkg::*;

    logic        awaiting_reg, awaiting_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  frame_address_reg, frame_address_next;
    logic [7:0]  frame_command_reg, frame_command_next;
    logic [63:0] frame_data_reg, frame_data_next;
    logic        advance;
    logic [2:0]  check_status;
    decode_t     dec;

    bmsr_decode u_decode (
        .frame_command (frame_command_reg),
        .frame_data    (frame_data_reg),
        .cells_in_pack (cfg.cells_in_pack),
        .dec           (dec)
    );

    // checksum, then address, then command range
    always_comb
    begin
        if (rx_byte != running_sum_reg)
            check_status = ST_BAD_SUM;
        else if (frame_address_reg != cfg.device_address)
            check_status = ST_BAD_ADDR;
        else if (frame_command_reg < CMD_MAIN || frame_command_reg > CMD_LAST)
            check_status = ST_BAD_CMD;
        else
            check_status = ST_OK;
    end

    // next state and result for one request
    always_comb
    begin
        awaiting_next      = awaiting_reg;
        byte_index_next    = byte_index_reg;
        running_sum_next   = running_sum_reg;
        elapsed_next       = elapsed_reg;
        frame_address_next = frame_address_reg;
        frame_command_next = frame_command_reg;
        frame_data_next    = frame_data_reg;
        advance            = 1'b0;
        res_valid          = 1'b0;
        res                = '0;
        if (step)
        begin
            case (func)
                FUNC_POLL:
                begin
                    awaiting_next    = 1'b1;
                    elapsed_next     = '0;
                    byte_index_next  = IDX_START;
                    running_sum_next = '0;
                end
                FUNC_TICK:
                begin
                    if (awaiting_reg)
                    begin
                        if (elapsed_reg >= cfg.reply_timeout_ticks)
                        begin
                            res_valid        = 1'b1;
                            res.status       = ST_TIMEOUT;
                            awaiting_next    = 1'b0;
                            byte_index_next  = IDX_START;
                            running_sum_next = '0;
                        end
                        else
                        begin
                            elapsed_next = elapsed_reg + 16'd1;
                        end
                    end
                end
                FUNC_BYTE:
                begin
                    if (awaiting_reg)
                    begin
                        if (byte_index_reg == IDX_START)
                        begin
                            // hunt for the start byte
                            if (rx_byte == START_BYTE)
                            begin
                                running_sum_next = rx_byte;
                                frame_data_next  = '0;
                                byte_index_next  = IDX_ADDR;
                            end
                        end
                        else if (byte_index_reg == IDX_ADDR)
                        begin
                            frame_address_next = rx_byte;
                            advance            = 1'b1;
                        end
                        else if (byte_index_reg == IDX_CMD)
                        begin
                            frame_command_next = rx_byte;
                            advance            = 1'b1;
                        end
                        else if (byte_index_reg == IDX_LEN)
                        begin
                            if (rx_byte != FRAME_LEN)
                            begin
                                res_valid        = 1'b1;
                                res.status       = ST_BAD_LEN;
                                res.command      = frame_command_reg;
                                awaiting_next    = 1'b0;
                                byte_index_next  = IDX_START;
                                running_sum_next = '0;
                            end
                            else
                            begin
                                advance = 1'b1;
                            end
                        end
                        else if (byte_index_reg < IDX_CHECKSUM)
                        begin
                            frame_data_next = {frame_data_reg[55:0], rx_byte};
                            advance         = 1'b1;
                        end
                        else
                        begin
                            // checksum byte closes the frame
                            res_valid        = 1'b1;
                            res.status       = check_status;
                            res.command      = frame_command_reg;
                            res.payload      = frame_data_reg;
                            byte_index_next  = IDX_START;
                            running_sum_next = '0;
                            if (check_status == ST_OK)
                            begin
                                res.value_a     = dec.value_a;
                                res.value_b     = dec.value_b;
                                res.value_c     = dec.value_c;
                                res.value_d     = dec.value_d;
                                res.cell_base   = dec.cell_base;
                                res.cell_count  = dec.cell_count;
                                res.more_frames = dec.more_frames;
                                res.followup    = dec.followup;
                                awaiting_next   = dec.keep_awaiting;
                                if (dec.keep_awaiting)
                                    elapsed_next = '0;
                            end
                            else
                            begin
                                awaiting_next = 1'b0;
                            end
                        end
                        if (advance)
                        begin
                            running_sum_next = running_sum_reg + rx_byte;
                            byte_index_next  = byte_index_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                    awaiting_next = awaiting_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg    <= 1'b0;
            byte_index_reg  <= IDX_START;
            running_sum_reg <= '0;
            elapsed_reg     <= '0;
        end
        else
        begin
            awaiting_reg    <= awaiting_next;
            byte_index_reg  <= byte_index_next;
            running_sum_reg <= running_sum_next;
            elapsed_reg     <= elapsed_next;
        end
    end

    // frame contents, always written before use
    always_ff @(posedge clk)
    begin
        frame_address_reg <= frame_address_next;
        frame_command_reg <= frame_command_next;
        frame_data_reg    <= frame_data_next;
    end

    // an idle receiver is always back at frame start
    a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        !awaiting_reg |-> (byte_index_reg == IDX_START && running_sum_reg == 8'd0))
        else $error("idle receiver holds a partial frame");

    // frame position never runs past the checksum byte
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= IDX_CHECKSUM)
        else $error("byte index beyond frame end");

    // a timeout only comes from a tick
    a_timeout_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && res.status == ST_TIMEOUT) |-> func == FUNC_TICK)
        else $error("timeout result without a tick");

    // a poll request restarts the reply window
    a_poll_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && func == FUNC_POLL) |=>
            (awaiting_reg && elapsed_reg == 16'd0 && byte_index_reg == IDX_START))
        else $error("poll did not restart reply tracking");

    // every result, timeouts and length errors included, leaves the receiver hunting again
    a_frame_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid) |=> byte_index_reg == IDX_START)
        else $error("result produced without returning to frame start");

endmodule

@@ hw/rtl/bms_status_frame_receiver.sv @@
// bms_status_frame_receiver: top level with input register, result register and config
//
//  channel  dir  handshake               payload
//  s_       in   s_tvalid / s_tready     s_tuser = func, s_tdata = rx_byte
//  m_       out  m_tvalid / m_tready     m_tuser = status, m_tdata = decoded frame
//  cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  one request per cycle while the result register can take a result; each request
//  waits in the input register, and any result that it yields is written to the result register
//  the result register decouples the output, so a waiting result still lets
//  the input register take a new request; processing holds while it is full and m_tready is low
//  rst_n clears reply tracking, the frame position and both register valids
//  configuration is always ready and takes effect on the next edge
module bms_status_frame_receiver (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic [1:0]   s_tuser,   // [1:0] func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // [7:0] command, [71:8] payload, [88:72] value_a,
                                    // [105:89] value_b, [122:106] value_c,
                                    // [139:123] value_d, [150:140] cell_base,
                                    // [152:151] cell_count, [153] more_frames,
                                    // [155:154] followup, [159:156] zero
    output logic [2:0]   m_tuser,   // [2:0] status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import bmsr_pkg::*;

    logic       in_valid_reg;
    logic [1:0] in_func_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    cfg_t       cfg_reg;
    logic       step;
    logic       res_valid;
    result_t    res;

    // processing moves when the result register can take a result
    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    bmsr_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .func      (in_func_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            out_reg <= res;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address      <= RST_DEVICE_ADDRESS;
            cfg_reg.cells_in_pack       <= RST_CELLS_IN_PACK;
            cfg_reg.reply_timeout_ticks <= RST_REPLY_TIMEOUT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address      <= cfg_data[7:0];
                CFG_CELLS_IN_PACK:  cfg_reg.cells_in_pack       <= cfg_data[5:0];
                CFG_REPLY_TIMEOUT:  cfg_reg.reply_timeout_ticks <= cfg_data;
                default:            cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {4'b0000, out_reg.followup, out_reg.more_frames,
                       out_reg.cell_count, out_reg.cell_base,
                       out_reg.value_d, out_reg.value_c, out_reg.value_b,
                       out_reg.value_a, out_reg.payload, out_reg.command};

endmodule

@@ test/tb_bms_status_frame_receiver.sv @@
`timescale 1ns / 1ps
// tb_bms_status_frame_receiver: self-checking stream testbench for the status frame receiver
module tb_bms_status_frame_receiver;
    import bmsr_pkg::*;

    // event kind outside the defined set, must be ignored
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // receiver stall patterns
    localparam logic [1:0] RX_OPEN = 2'd0;
    localparam logic [1:0] RX_BEAT = 2'd1;
    localparam logic [1:0] RX_COIN = 2'd2;
    localparam logic [1:0] RX_HOLD = 2'd3;

    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_ITEMS  = 180;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } rx_event_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [159:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_data  = '0;

    // events waiting to be sent and results waiting to arrive
    rx_event_t event_queue [$];
    result_t   expected_results [$];

    // shadow of the configuration registers
    logic [7:0]  node_addr     = RST_DEVICE_ADDRESS;
    logic [5:0]  pack_cells    = RST_CELLS_IN_PACK;
    logic [15:0] timeout_ticks = RST_REPLY_TIMEOUT;

    // shadow of the receiver state
    logic        awaiting   = 1'b0;
    logic [3:0]  frame_pos  = IDX_START;
    logic [7:0]  frame_sum  = '0;
    logic [7:0]  frame_addr = '0;
    logic [7:0]  frame_cmd  = '0;
    logic [63:0] frame_data = '0;
    logic [15:0] tick_count = '0;

    int errors      = 0;
    int phase_items = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int rx_cycle    = 0;
    logic [1:0] rx_mode = RX_OPEN;

    bms_status_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // data byte k of the frame, data 0 in the top byte
    function automatic int byte_at(input int k);
        return int'(frame_data[63 - 8 * k -: 8]);
    endfunction

    function automatic int word_at(input int k);
        return byte_at(k) * 256 + byte_at(k + 1);
    endfunction

    task automatic end_reply();
        awaiting  = 1'b0;
        frame_pos = IDX_START;
        frame_sum = '0;
    endtask

    // advance the shadow receiver by one event, queue the result it yields
    task automatic receive_event(input logic [1:0] func, input logic [7:0] rx);
        result_t r;
        bit      emit;
        int      fr;
        int      n;
        int      base;
        int      cnt;
        r    = '0;
        emit = 1'b0;
        case (func)
            FUNC_POLL:
            begin
                awaiting   = 1'b1;
                tick_count = '0;
                frame_pos  = IDX_START;
                frame_sum  = '0;
            end
            FUNC_TICK:
            begin
                if (awaiting)
                begin
                    if (tick_count >= timeout_ticks)
                    begin
                        r.status = ST_TIMEOUT;
                        emit     = 1'b1;
                        end_reply();
                    end
                    else
                        tick_count = tick_count + 16'd1;
                end
            end
            FUNC_BYTE:
            begin
                if (!awaiting)
                    ;
                else if (frame_pos == IDX_START)
                begin
                    // hunting for the start byte
                    if (rx == START_BYTE)
                    begin
                        frame_sum  = rx;
                        frame_data = '0;
                        frame_pos  = IDX_ADDR;
                    end
                end
                else if (frame_pos == IDX_LEN && rx != FRAME_LEN)
                begin
                    r.status  = ST_BAD_LEN;
                    r.command = frame_cmd;
                    emit      = 1'b1;
                    end_reply();
                end
                else if (frame_pos == IDX_CHECKSUM)
                begin
                    emit      = 1'b1;
                    r.command = frame_cmd;
                    r.payload = frame_data;
                    if (rx != frame_sum)
                        r.status = ST_BAD_SUM;
                    else if (frame_addr != node_addr)
                        r.status = ST_BAD_ADDR;
                    else if (frame_cmd < CMD_MAIN || frame_cmd > CMD_LAST)
                        r.status = ST_BAD_CMD;
                    else
                        r.status = ST_OK;
                    // decode a good frame into integer units
                    if (r.status != ST_OK)
                        end_reply();
                    else if (frame_cmd == CMD_MAIN)
                    begin
                        r.value_a  = 17'(word_at(0));
                        r.value_b  = 17'(word_at(4) - int'(CURRENT_OFFSET));
                        r.value_c  = 17'(word_at(6));
                        r.followup = FOLLOW_CELLS;
                        tick_count = '0;
                    end
                    else if (frame_cmd == CMD_CELLS)
                    begin
                        r.value_a  = 17'(word_at(0));
                        r.value_b  = 17'(byte_at(2) - int'(INDEX_OFFSET));
                        r.value_c  = 17'(word_at(3));
                        r.value_d  = 17'(byte_at(5) - int'(INDEX_OFFSET));
                        r.followup = FOLLOW_NEXT;
                        tick_count = '0;
                    end
                    else if (frame_cmd == CMD_TEMPS)
                    begin
                        r.value_a = 17'(byte_at(0) - int'(TEMP_OFFSET));
                        r.value_b = 17'(byte_at(1) - int'(INDEX_OFFSET));
                        r.value_c = 17'(byte_at(2) - int'(TEMP_OFFSET));
                        r.value_d = 17'(byte_at(3) - int'(INDEX_OFFSET));
                        end_reply();
                    end
                    else if (frame_cmd == CMD_VOLTS)
                    begin
                        // three cells per frame, clipped at the pack size
                        fr   = byte_at(0);
                        n    = int'(pack_cells);
                        base = (fr - 1) * 3;
                        cnt  = 0;
                        if (base < n)
                            cnt = (n - base > 3) ? 3 : n - base;
                        r.value_a    = (cnt > 0) ? 17'(word_at(1)) : 17'd0;
                        r.value_b    = (cnt > 1) ? 17'(word_at(3)) : 17'd0;
                        r.value_c    = (cnt > 2) ? 17'(word_at(5)) : 17'd0;
                        r.cell_base  = 11'(base);
                        r.cell_count = 2'(cnt);
                        if (fr < (n + 2) / 3)
                        begin
                            r.more_frames = 1'b1;
                            tick_count    = '0;
                        end
                        else
                            end_reply();
                    end
                    else
                        end_reply();
                    frame_pos = IDX_START;
                    frame_sum = '0;
                end
                else
                begin
                    // header and data bytes
                    if (frame_pos == IDX_ADDR)
                        frame_addr = rx;
                    else if (frame_pos == IDX_CMD)
                        frame_cmd = rx;
                    else if (frame_pos != IDX_LEN)
                        frame_data = {frame_data[55:0], rx};
                    frame_sum = frame_sum + rx;
                    frame_pos = frame_pos + 4'd1;
                end
            end
            default:
                ;
        endcase
        if (emit)
            expected_results.push_back(r);
    endtask

    function automatic string show(input result_t r);
        return {$sformatf("st=%0d cmd=%02h pl=%016h ", r.status, r.command, r.payload),
                $sformatf("a=%0d b=%0d c=%0d d=%0d ", $signed(r.value_a),
                          $signed(r.value_b), $signed(r.value_c), $signed(r.value_d)),
                $sformatf("base=%0d cnt=%0d more=%0d fu=%0d", $signed(r.cell_base),
                          r.cell_count, r.more_frames, r.followup)};
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // stimulus builders
    task automatic queue_event(input logic [1:0] func, input logic [7:0] rx);
        rx_event_t ev;
        ev.func    = func;
        ev.rx_byte = rx;
        event_queue.push_back(ev);
        phase_items++;
    endtask

    task automatic queue_byte(input logic [7:0] rx, input bit noisy);
        if (noisy && $urandom_range(0, 99) < 3)
            queue_event(FUNC_TICK, 8'($urandom));
        queue_event(FUNC_BYTE, rx);
    endtask

    task automatic queue_frame(input logic [7:0] addr, input logic [7:0] cmd,
                               input logic [7:0] len, input logic [63:0] data,
                               input bit bad_sum, input bit noisy);
        logic [7:0] sum;
        int         k;
        sum = START_BYTE + addr + cmd + len;
        queue_byte(START_BYTE, noisy);
        queue_byte(addr, noisy);
        queue_byte(cmd, noisy);
        queue_byte(len, noisy);
        if (len == FRAME_LEN)
        begin
            for (k = 0; k < 8; k++)
            begin
                queue_byte(data[63 - 8 * k -: 8], noisy);
                sum = sum + data[63 - 8 * k -: 8];
            end
            if (bad_sum)
                sum = sum + 8'($urandom_range(1, 255));
            queue_byte(sum, noisy);
        end
    endtask

    // one reply frame, mostly well formed; frame_no below zero leaves data 0 random
    task automatic queue_reply(input logic [7:0] cmd, input int frame_no);
        int          pick;
        logic [7:0]  addr;
        logic [7:0]  len;
        logic [63:0] data;
        bit          bad_sum;
        addr    = node_addr;
        len     = FRAME_LEN;
        bad_sum = 1'b0;
        pick    = $urandom_range(0, 99);
        if (pick < 5)
        begin
            len = 8'($urandom);
            if (len == FRAME_LEN)
                len = 8'h00;
        end
        else if (pick < 10)
            bad_sum = 1'b1;
        else if (pick < 15)
            addr = node_addr ^ 8'($urandom_range(1, 255));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            data = '0;
        else if (pick == 1)
            data = '1;
        else
            data = {$urandom, $urandom};
        if (frame_no >= 0)
            data[63:56] = 8'(frame_no);
        queue_frame(addr, cmd, len, data, bad_sum, 1'b1);
    endtask

    // one poll exchange, or a short burst of noise
    task automatic queue_exchange();
        int         kind;
        int         groups;
        int         k;
        logic [7:0] noise;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 6))
                queue_event(2'($urandom_range(0, 3)), 8'($urandom));
        end
        else
        begin
            queue_event(FUNC_POLL, 8'($urandom));
            repeat ($urandom_range(0, 2))
            begin
                noise = 8'($urandom);
                if (noise == START_BYTE)
                    noise = ~noise;
                queue_byte(noise, 1'b1);
            end
            if (kind < 35)
            begin
                queue_reply(CMD_MAIN, -1);
                queue_reply(CMD_CELLS, -1);
            end
            else if (kind < 55)
            begin
                groups = (int'(pack_cells) + 2) / 3;
                if (groups == 0)
                    groups = 1;
                if ($urandom_range(0, 4) == 0)
                    queue_reply(CMD_VOLTS, $urandom_range(0, 255));
                else
                    for (k = 1; k <= groups; k++)
                        queue_reply(CMD_VOLTS, k);
            end
            else if (kind < 85)
            begin
                if ($urandom_range(0, 9) < 7)
                    queue_reply(8'(CMD_MAIN + $urandom_range(0, 8)), -1);
                else
                    queue_reply(8'($urandom), -1);
            end
            else if (timeout_ticks <= 16'd64)
                repeat (int'(timeout_ticks) + 1)
                    queue_event(FUNC_TICK, 8'($urandom));
            else
            begin
                repeat ($urandom_range(1, 5))
                    queue_event(FUNC_TICK, 8'($urandom));
                queue_reply(CMD_TEMPS, -1);
            end
        end
    endtask

    // write all three registers back to back; unused data bits carry noise
    task automatic write_config(input logic [7:0] addr, input logic [5:0] cells,
                                input logic [15:0] ticks);
        logic [1:0]  idx [3];
        logic [15:0] val [3];
        int          i;
        idx[0] = CFG_DEVICE_ADDRESS;
        idx[1] = CFG_CELLS_IN_PACK;
        idx[2] = CFG_REPLY_TIMEOUT;
        val[0] = {8'($urandom), addr};
        val[1] = {10'($urandom), cells};
        val[2] = ticks;
        @(posedge clk);
        cfg_valid <= 1'b1;
        for (i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid     <= 1'b0;
        node_addr     = addr;
        pack_cells    = cells;
        timeout_ticks = ticks;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (event_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        rx_event_t ev;
        bit        busy;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            busy = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                receive_event(s_tuser, s_tdata);
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (event_queue.size() != 0)
                begin
                    ev = event_queue.pop_front();
                    s_tdata  <= ev.rx_byte;
                    s_tuser  <= ev.func;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern drawn anew at random from the four patterns above
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 128 == 0)
                rx_mode <= 2'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN: m_tready <= 1'b1;
                RX_BEAT: m_tready <= (rx_cycle % 4) != 3;
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                RX_HOLD: m_tready <= (rx_cycle % 64) >= 24;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin : check_blk
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status      = m_tuser;
            got.command     = m_tdata[7:0];
            got.payload     = m_tdata[71:8];
            got.value_a     = m_tdata[88:72];
            got.value_b     = m_tdata[105:89];
            got.value_c     = m_tdata[122:106];
            got.value_d     = m_tdata[139:123];
            got.cell_base   = m_tdata[150:140];
            got.cell_count  = m_tdata[152:151];
            got.more_frames = m_tdata[153];
            got.followup    = m_tdata[155:154];
            if (expected_results.size() == 0)
                note_failure($sformatf("unexpected result %s", show(got)));
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                    note_failure($sformatf("expected %s got %s", show(want), show(got)));
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int p;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle events, spare kind, noise, short length, start byte inside data
        queue_event(FUNC_BYTE, START_BYTE);
        queue_event(FUNC_TICK, 8'hFF);
        queue_event(FUNC_SPARE, 8'hFF);
        queue_event(FUNC_POLL, 8'h00);
        queue_event(FUNC_BYTE, 8'h00);
        queue_frame(RST_DEVICE_ADDRESS, CMD_MAIN, 8'h07, '0, 1'b0, 1'b0);
        queue_event(FUNC_POLL, 8'hFF);
        queue_frame(RST_DEVICE_ADDRESS, CMD_CELLS, FRAME_LEN, 64'hA5FF00A5_00001234,
                    1'b0, 1'b0);
        wait_idle();

        // random phases across register settings, extremes first
        for (p = 0; p < 6; p++)
        begin
            if (p == 0)
                write_config(8'h00, 6'd0, 16'd1);
            else if (p == 1)
                write_config(8'hFF, 6'd48, 16'hFFFF);
            else
                write_config(8'($urandom), 6'($urandom_range(0, 48)),
                             16'($urandom_range(2, 30)));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                queue_exchange();
            wait_idle();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bmsr_pkg.sv
hw/rtl/bmsr_decode.sv
hw/rtl/bmsr_frame.sv
hw/rtl/bms_status_frame_receiver.sv
test/tb_bms_status_frame_receiver.sv
